// ===== hdl/setc_pkg.sv =====
// shared constants for the scope edge trigger capture block
`default_nettype none

package setc_pkg;

    localparam int RING_DEPTH_DFLT     = 2048;
    localparam int WINDOW_SAMPLES_DFLT = 128;
    localparam int SAMPLE_WIDTH_DFLT   = 12;

    localparam int IN_SAMPLE_W  = 12;
    localparam int OUT_SAMPLE_W = 12;
    localparam int LEVEL_W      = 12;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 12;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 12'd2048;

    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_FALLING = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_LEVEL   = 2'd1;

    localparam logic ACTION_STORE   = 1'b0;
    localparam logic ACTION_CAPTURE = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/setc_ring.sv =====
// sample ring memory with auto-advancing write pointer and fill tracking
`default_nettype none

module setc_ring #(
    parameter int RING_DEPTH   = setc_pkg::RING_DEPTH_DFLT,
    parameter int SAMPLE_WIDTH = setc_pkg::SAMPLE_WIDTH_DFLT,
    parameter int ADDR_W       = $clog2(RING_DEPTH)
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    wr_en,
    input  wire logic [SAMPLE_WIDTH-1:0] wr_data,
    output logic      [ADDR_W-1:0]       wr_ptr,
    input  wire logic                    rd_en,
    input  wire logic [ADDR_W-1:0]       rd_addr,
    output logic      [SAMPLE_WIDTH-1:0] rd_data
);
    import setc_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);

    logic [SAMPLE_WIDTH-1:0] mem [RING_DEPTH];
    logic [ADDR_W-1:0]       wp_reg;
    logic [ADDR_W-1:0]       wp_next;
    logic                    full_reg;
    logic [SAMPLE_WIDTH-1:0] rd_q_reg;
    logic                    rd_ok_reg;
    logic                    rd_ok_next;

    assign wp_next    = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
    // entries 1..wp are written until the pointer first wraps to zero
    assign rd_ok_next = full_reg || ((rd_addr != '0) && (rd_addr <= wp_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            full_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                wp_reg <= wp_next;
                if (wp_next == '0) begin
                    full_reg <= 1'b1;
                end
            end
            if (rd_en) begin
                rd_ok_reg <= rd_ok_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_next] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign wr_ptr  = wp_reg;
    assign rd_data = rd_ok_reg ? rd_q_reg : '0;

    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |=> full_reg)
        else $error("ring full flag dropped");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("ring read and write in the same cycle");

    a_unwritten_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && !full_reg && (rd_addr == '0)) |=> (rd_data == '0))
        else $error("unwritten ring entry read as nonzero");

endmodule

`default_nettype wire

// ===== hdl/scope_edge_trigger_capture.sv =====
// top level: sample ring, edge trigger search and window readout
//
// s_ channel: one transaction per item. action 0 stores s_sample_value at the
// next ring position; s_ready stays high for it, so a stream of samples is
// accepted every cycle while no capture runs. action 1 starts a capture.
// A capture walks backward over half the ring, one ring read per cycle through
// the single memory read port, ending early at the first matching edge. The
// window is then read back, each result taking two ring reads and an output
// load, WINDOW_SAMPLES/2 results, the final one marked by m_window_last.
// s_ready is low from capture accept until the final result has been loaded
// into the output register.
// m_ channel: a registered output; when the receiver stalls, the readout
// holds and resumes as soon as the pending result is taken.
// cfg_ channel: always ready; index 0 bit 0 selects falling (1) or rising (0)
// edge, index 1 sets the level. Other indexes are ignored.
// reset: the ring reads as all zeros and the write pointer is zero; no
// clearing pass is needed, unwritten entries are tracked by the fill state.
`default_nettype none

module scope_edge_trigger_capture #(
    parameter int RING_DEPTH     = setc_pkg::RING_DEPTH_DFLT,
    parameter int WINDOW_SAMPLES = setc_pkg::WINDOW_SAMPLES_DFLT,
    parameter int SAMPLE_WIDTH   = setc_pkg::SAMPLE_WIDTH_DFLT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_action,
    input  wire logic [setc_pkg::IN_SAMPLE_W-1:0]   s_sample_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [setc_pkg::OUT_SAMPLE_W-1:0]  m_sample_even,
    output logic      [setc_pkg::OUT_SAMPLE_W-1:0]  m_sample_odd,
    output logic                                    m_window_last,
    output logic                                    m_edge_found,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [setc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [setc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import setc_pkg::*;

    localparam int ADDR_W    = $clog2(RING_DEPTH);
    localparam int HALF_WIN  = WINDOW_SAMPLES / 2;
    localparam int HALF_RING = RING_DEPTH / 2;
    localparam int CNT_W     = $clog2(HALF_RING + 1);
    localparam int PAIR_W    = $clog2(HALF_WIN + 1);
    localparam int CMP_W     = (SAMPLE_WIDTH > LEVEL_W) ? SAMPLE_WIDTH : LEVEL_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(RING_DEPTH - 1);
    localparam logic [ADDR_W-1:0] HALF_WIN_A    = ADDR_W'(HALF_WIN);
    localparam logic [CNT_W-1:0]  HALF_RING_C   = CNT_W'(HALF_RING);
    localparam logic [CNT_W-1:0]  LAST_EVAL_C   = CNT_W'(HALF_RING - 1);
    localparam logic [PAIR_W-1:0] LAST_PAIR     = PAIR_W'(HALF_WIN - 1);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SEARCH  = 5'b00010,
        ST_RD_EVEN = 5'b00100,
        ST_RD_ODD  = 5'b01000,
        ST_LOAD    = 5'b10000
    } state_t;

    function automatic logic [ADDR_W-1:0] ring_sub(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] d);
        logic [ADDR_W:0] t;
        t = {1'b0, a} + (ADDR_W + 1)'(RING_DEPTH) - {1'b0, d};
        return (a >= d) ? (a - d) : ADDR_W'(t);
    endfunction

    function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] a);
        return (a == '0) ? LAST_ADDR : a - 1'b1;
    endfunction

    state_t                   state_reg, state_next;
    logic                     falling_reg;
    logic [LEVEL_W-1:0]       level_reg;
    logic [ADDR_W-1:0]        start_reg, start_next;
    logic [ADDR_W-1:0]        issue_addr_reg, issue_addr_next;
    logic [CNT_W-1:0]         issue_cnt_reg, issue_cnt_next;
    logic [ADDR_W-1:0]        eval_addr_reg, eval_addr_next;
    logic                     eval_valid_reg, eval_valid_next;
    logic [CNT_W-1:0]         eval_cnt_reg, eval_cnt_next;
    logic                     prev_high_reg, prev_high_next;
    logic                     found_reg, found_next;
    logic [ADDR_W-1:0]        win_addr_reg, win_addr_next;
    logic [PAIR_W-1:0]        pair_cnt_reg, pair_cnt_next;
    logic [SAMPLE_WIDTH-1:0]  even_hold_reg, even_hold_next;
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_SAMPLE_W-1:0]  m_even_reg, m_even_next;
    logic [OUT_SAMPLE_W-1:0]  m_odd_reg, m_odd_next;
    logic                     m_last_reg, m_last_next;
    logic                     m_found_reg, m_found_next;

    logic                     s_fire;
    logic                     wr_en;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_ptr;
    logic [SAMPLE_WIDTH-1:0]  rd_data;
    logic                     cur_high;
    logic                     hit;
    logic                     out_free;

    setc_ring #(
        .RING_DEPTH   (RING_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ADDR_W       (ADDR_W)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_data (SAMPLE_WIDTH'(s_sample_value)),
        .wr_ptr  (wr_ptr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign wr_en     = s_fire && (s_action == ACTION_STORE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign cur_high = CMP_W'(rd_data) > CMP_W'(level_reg);
    assign hit      = falling_reg ? (!prev_high_reg && cur_high)
                                  : (prev_high_reg && !cur_high);

    always_comb begin
        state_next      = state_reg;
        start_next      = start_reg;
        issue_addr_next = issue_addr_reg;
        issue_cnt_next  = issue_cnt_reg;
        eval_addr_next  = eval_addr_reg;
        eval_valid_next = 1'b0;
        eval_cnt_next   = eval_cnt_reg;
        prev_high_next  = prev_high_reg;
        found_next      = found_reg;
        win_addr_next   = win_addr_reg;
        pair_cnt_next   = pair_cnt_reg;
        even_hold_next  = even_hold_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_even_next     = m_even_reg;
        m_odd_next      = m_odd_reg;
        m_last_next     = m_last_reg;
        m_found_next    = m_found_reg;
        rd_en           = 1'b0;
        rd_addr         = issue_addr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_action == ACTION_CAPTURE)) begin
                    start_next      = ring_sub(wr_ptr, HALF_WIN_A);
                    issue_addr_next = ring_sub(wr_ptr, HALF_WIN_A);
                    issue_cnt_next  = '0;
                    eval_cnt_next   = '0;
                    prev_high_next  = 1'b0;
                    state_next      = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // one read issued per cycle, compared the cycle after
                if (issue_cnt_reg != HALF_RING_C) begin
                    rd_en           = 1'b1;
                    rd_addr         = issue_addr_reg;
                    issue_addr_next = ring_dec(issue_addr_reg);
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                    eval_addr_next  = issue_addr_reg;
                    eval_valid_next = 1'b1;
                end
                if (eval_valid_reg) begin
                    if (hit) begin
                        found_next      = 1'b1;
                        win_addr_next   = ring_sub(eval_addr_reg, HALF_WIN_A);
                        pair_cnt_next   = '0;
                        eval_valid_next = 1'b0;
                        state_next      = ST_RD_EVEN;
                    end else if (eval_cnt_reg == LAST_EVAL_C) begin
                        found_next      = 1'b0;
                        win_addr_next   = ring_sub(start_reg, HALF_WIN_A);
                        pair_cnt_next   = '0;
                        eval_valid_next = 1'b0;
                        state_next      = ST_RD_EVEN;
                    end else begin
                        prev_high_next = cur_high;
                        eval_cnt_next  = eval_cnt_reg + 1'b1;
                    end
                end
            end
            ST_RD_EVEN: begin
                rd_en         = 1'b1;
                rd_addr       = win_addr_reg;
                win_addr_next = ring_inc(win_addr_reg);
                state_next    = ST_RD_ODD;
            end
            ST_RD_ODD: begin
                rd_en          = 1'b1;
                rd_addr        = win_addr_reg;
                win_addr_next  = ring_inc(win_addr_reg);
                even_hold_next = rd_data;
                state_next     = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_even_next  = OUT_SAMPLE_W'(even_hold_reg);
                    m_odd_next   = OUT_SAMPLE_W'(rd_data);
                    m_last_next  = (pair_cnt_reg == LAST_PAIR);
                    m_found_next = found_reg;
                    if (pair_cnt_reg == LAST_PAIR) begin
                        state_next = ST_IDLE;
                    end else begin
                        pair_cnt_next = pair_cnt_reg + 1'b1;
                        state_next    = ST_RD_EVEN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            falling_reg    <= 1'b0;
            level_reg      <= LEVEL_RESET;
            eval_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            eval_valid_reg <= eval_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_TRIGGER_FALLING: falling_reg <= cfg_data[0];
                    CFG_TRIGGER_LEVEL:   level_reg   <= LEVEL_W'(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        start_reg      <= start_next;
        issue_addr_reg <= issue_addr_next;
        issue_cnt_reg  <= issue_cnt_next;
        eval_addr_reg  <= eval_addr_next;
        eval_cnt_reg   <= eval_cnt_next;
        prev_high_reg  <= prev_high_next;
        found_reg      <= found_next;
        win_addr_reg   <= win_addr_next;
        pair_cnt_reg   <= pair_cnt_next;
        even_hold_reg  <= even_hold_next;
        m_even_reg     <= m_even_next;
        m_odd_reg      <= m_odd_next;
        m_last_reg     <= m_last_next;
        m_found_reg    <= m_found_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_sample_even = m_even_reg;
    assign m_sample_odd  = m_odd_reg;
    assign m_window_last = m_last_reg;
    assign m_edge_found  = m_found_reg;

    a_capture_starts_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_action == ACTION_CAPTURE)) |=> (state_reg == ST_SEARCH))
        else $error("capture transaction did not start a search");

    a_eval_trails_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |->
            ((eval_cnt_reg <= issue_cnt_reg) && (issue_cnt_reg <= HALF_RING_C)))
        else $error("search compare ran ahead of ring reads");

    a_pair_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RD_EVEN) || (state_reg == ST_RD_ODD) || (state_reg == ST_LOAD))
            |-> (pair_cnt_reg <= LAST_PAIR))
        else $error("window pair count out of range");

    a_last_ends_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_LOAD) && out_free && (pair_cnt_reg == LAST_PAIR))
            |=> (s_ready && m_valid && m_window_last))
        else $error("final pair did not close the capture");

endmodule

`default_nettype wire

// ===== verif/scope_edge_trigger_capture_checker.sv =====
// checker for the scope edge trigger capture block: ring copy, window prediction, compare
module scope_edge_trigger_capture_checker #(
    parameter int RING_DEPTH     = setc_pkg::RING_DEPTH_DFLT,
    parameter int WINDOW_SAMPLES = setc_pkg::WINDOW_SAMPLES_DFLT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_action,
    input  logic [setc_pkg::IN_SAMPLE_W-1:0]  s_sample_value,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [setc_pkg::OUT_SAMPLE_W-1:0] m_sample_even,
    input  logic [setc_pkg::OUT_SAMPLE_W-1:0] m_sample_odd,
    input  logic                              m_window_last,
    input  logic                              m_edge_found,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [setc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [setc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                fail_count,
    output int                                pending_pairs,
    output int                                captures_seen,
    output int                                edges_found,
    output int                                pairs_checked
);
    import setc_pkg::*;

    localparam int PTR_W    = $clog2(RING_DEPTH);
    localparam int HALF_WIN = WINDOW_SAMPLES / 2;
    localparam logic [PTR_W-1:0] HALF_WIN_OFS = PTR_W'(HALF_WIN);

    typedef struct packed {
        logic [OUT_SAMPLE_W-1:0] even;
        logic [OUT_SAMPLE_W-1:0] odd;
        logic                    last;
        logic                    found;
    } window_pair_t;

    logic [OUT_SAMPLE_W-1:0] ring_copy [RING_DEPTH];
    logic [PTR_W-1:0]        wr_ptr;
    logic                    falling_mode;
    logic [LEVEL_W-1:0]      level;
    window_pair_t            window_pairs [$];
    window_pair_t            got;
    window_pair_t            want;

    // backward edge search, then queue the window around the trigger point
    function automatic void predict_window();
        logic [PTR_W-1:0] start_pos;
        logic [PTR_W-1:0] pos;
        logic [PTR_W-1:0] first;
        logic [PTR_W-1:0] idx;
        logic             prev_high;
        logic             cur_high;
        logic             hit;
        window_pair_t     pair;
        start_pos = wr_ptr - HALF_WIN_OFS;
        pos       = start_pos;
        prev_high = 1'b0;
        hit       = 1'b0;
        for (int n = 0; n < RING_DEPTH / 2; n++) begin
            if (!hit) begin
                cur_high = ring_copy[pos] > level;
                if (!falling_mode && prev_high && !cur_high) begin
                    hit = 1'b1;
                end else if (falling_mode && !prev_high && cur_high) begin
                    hit = 1'b1;
                end else begin
                    prev_high = cur_high;
                    pos = pos - 1'b1;
                end
            end
        end
        if (!hit) begin
            pos = start_pos;
        end
        first = pos - HALF_WIN_OFS;
        for (int k = 0; k < HALF_WIN; k++) begin
            idx        = first + PTR_W'(2 * k);
            pair.even  = ring_copy[idx];
            pair.odd   = ring_copy[idx + 1'b1];
            pair.last  = (k == HALF_WIN - 1);
            pair.found = hit;
            window_pairs.push_back(pair);
        end
        captures_seen = captures_seen + 1;
        if (hit) begin
            edges_found = edges_found + 1;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring_copy[i] = '0;
            end
            wr_ptr        = '0;
            falling_mode  = 1'b0;
            level         = LEVEL_RESET;
            fail_count    = 0;
            captures_seen = 0;
            edges_found   = 0;
            pairs_checked = 0;
            window_pairs.delete();
        end else begin
            // a result taken at this edge cannot come from a capture taken at it
            if (m_valid && m_ready) begin
                got = '{m_sample_even, m_sample_odd, m_window_last, m_edge_found};
                if (window_pairs.size() == 0) begin
                    $display("%0t: unexpected result even %0d odd %0d last %0d found %0d",
                             $time, got.even, got.odd, got.last, got.found);
                    fail_count = fail_count + 1;
                end else begin
                    want = window_pairs.pop_front();
                    pairs_checked = pairs_checked + 1;
                    if (got.even !== want.even || got.odd !== want.odd ||
                        got.last !== want.last || got.found !== want.found) begin
                        $display("%0t: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 $time, want.even, want.odd, want.last, want.found,
                                 got.even, got.odd, got.last, got.found);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TRIGGER_FALLING: falling_mode = cfg_data[0];
                    CFG_TRIGGER_LEVEL:   level = cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_action == ACTION_STORE) begin
                    wr_ptr = wr_ptr + 1'b1;
                    ring_copy[wr_ptr] = s_sample_value[OUT_SAMPLE_W-1:0];
                end else begin
                    predict_window();
                end
            end
        end
        pending_pairs = window_pairs.size();
    end

endmodule

// ===== verif/tb_scope_edge_trigger_capture.sv =====
// testbench top for the scope edge trigger capture block: stimulus, flow control and verdict
module tb_scope_edge_trigger_capture;
    import setc_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int FILL_SAMPLES  = 120;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 40;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 2'd3;
    localparam logic [LEVEL_W-1:0]     LEVEL_MAX       = 12'd4095;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE} ready_mode_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_action;
    logic [IN_SAMPLE_W-1:0]  s_sample_value;
    logic                    m_valid;
    logic                    m_ready;
    logic [OUT_SAMPLE_W-1:0] m_sample_even;
    logic [OUT_SAMPLE_W-1:0] m_sample_odd;
    logic                    m_window_last;
    logic                    m_edge_found;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int fail_count;
    int pending_pairs;
    int captures_seen;
    int edges_found;
    int pairs_checked;

    int          burst_left;
    int          samples_sent;
    int          settings_used;
    int          cur_level;
    int          trace_pos;
    int          trace_period;
    int          trace_hi;
    int          trace_lo;
    logic        trace_ramp;
    ready_mode_t ready_mode;
    logic [7:0]  ready_mask;
    int          ready_step;
    int          pick;

    scope_edge_trigger_capture dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_sample_value (s_sample_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_even  (m_sample_even),
        .m_sample_odd   (m_sample_odd),
        .m_window_last  (m_window_last),
        .m_edge_found   (m_edge_found),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    scope_edge_trigger_capture_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_sample_value (s_sample_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_even  (m_sample_even),
        .m_sample_odd   (m_sample_odd),
        .m_window_last  (m_window_last),
        .m_edge_found   (m_edge_found),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_pairs  (pending_pairs),
        .captures_seen  (captures_seen),
        .edges_found    (edges_found),
        .pairs_checked  (pairs_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("scope_edge_trigger_capture: mismatch");
        $finish;
    end

    // receiver stalls under a ready pattern that is picked at random again after each run
    initial begin
        m_ready    = 1'b0;
        ready_step = 0;
        forever begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_mask = 8'($urandom_range(1, 255));
            repeat ($urandom_range(50, 400)) begin
                @(negedge aclk);
                ready_step = ready_step + 1;
                case (ready_mode)
                    READY_ALWAYS:  m_ready <= 1'b1;
                    READY_COIN:    m_ready <= 1'($urandom_range(0, 1));
                    READY_PATTERN: m_ready <= ready_mask[ready_step % 8];
                    default:       m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic act, input logic [IN_SAMPLE_W-1:0] value);
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_action       <= act;
        s_sample_value <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (act == ACTION_STORE) begin
            samples_sent = samples_sent + 1;
        end
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // sender in bursts with random gaps between them
    task automatic feed_item(input logic act, input logic [IN_SAMPLE_W-1:0] value);
        send_item(act, value);
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 120);
            end else begin
                pause_sender($urandom_range(1, 10));
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic settle_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pairs != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_TRIGGER_LEVEL) begin
            cur_level = int'(data);
        end
        settings_used = settings_used + 1;
    endtask

    // square or ramp trace swinging across the current level
    function automatic logic [IN_SAMPLE_W-1:0] next_trace_sample();
        int v;
        if (trace_pos >= trace_period) begin
            trace_pos    = 0;
            trace_period = $urandom_range(4, 160);
            trace_hi     = cur_level + $urandom_range(1, 600);
            trace_lo     = cur_level - $urandom_range(0, 600);
            trace_ramp   = ($urandom_range(0, 3) == 0);
            if (trace_hi > 4095) trace_hi = 4095;
            if (trace_lo < 0) trace_lo = 0;
        end
        if (trace_ramp) begin
            v = trace_lo + (trace_hi - trace_lo) * trace_pos / trace_period;
        end else begin
            v = (trace_pos < trace_period / 2) ? trace_hi : trace_lo;
        end
        trace_pos = trace_pos + 1;
        return IN_SAMPLE_W'(v);
    endfunction

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = ACTION_STORE;
        s_sample_value = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_TRIGGER_FALLING;
        cfg_data       = '0;
        burst_left     = 8;
        samples_sent   = 0;
        settings_used  = 0;
        cur_level      = int'(LEVEL_RESET);
        trace_pos      = 0;
        trace_period   = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty ring, field extremes, both edge modes, level extremes
        send_item(ACTION_CAPTURE, 12'd4095);
        send_item(ACTION_STORE, 12'd0);
        send_item(ACTION_STORE, 12'd4095);
        send_item(ACTION_STORE, 12'd2048);
        send_item(ACTION_STORE, 12'd2049);
        send_item(ACTION_CAPTURE, 12'd0);
        settle_results();
        write_reg(CFG_TRIGGER_FALLING, {11'($urandom), 1'b1});
        send_item(ACTION_CAPTURE, 12'd0);
        settle_results();
        write_reg(CFG_TRIGGER_LEVEL, '0);
        send_item(ACTION_STORE, 12'd1);
        send_item(ACTION_CAPTURE, 12'd0);
        settle_results();
        write_reg(CFG_TRIGGER_LEVEL, LEVEL_MAX);
        write_reg(CFG_TRIGGER_FALLING, {11'($urandom), 1'b0});
        send_item(ACTION_STORE, 12'd4095);
        send_item(ACTION_CAPTURE, 12'd0);
        settle_results();
        // write to an index past the register list is ignored
        write_reg(CFG_INDEX_SPARE, 12'hfff);
        send_item(ACTION_CAPTURE, 12'd0);
        settle_results();

        // stream a trace, no idling
        write_reg(CFG_TRIGGER_LEVEL, LEVEL_RESET);
        repeat (FILL_SAMPLES) send_item(ACTION_STORE, next_trace_sample());
        send_item(ACTION_CAPTURE, '0);
        send_item(ACTION_CAPTURE, '0);
        settle_results();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_TRIGGER_FALLING, {11'($urandom), p[0]});
            case (p)
                2:       write_reg(CFG_TRIGGER_LEVEL, '0);
                3:       write_reg(CFG_TRIGGER_LEVEL, LEVEL_MAX);
                5:       write_reg(CFG_TRIGGER_LEVEL, 12'd1);
                6:       write_reg(CFG_TRIGGER_LEVEL, 12'd4094);
                default: write_reg(CFG_TRIGGER_LEVEL, 12'($urandom_range(300, 3800)));
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 11) begin
                    feed_item(ACTION_CAPTURE, 12'($urandom_range(0, 4095)));
                end else if (pick < 76) begin
                    feed_item(ACTION_STORE, next_trace_sample());
                end else if (pick < 90) begin
                    feed_item(ACTION_STORE, 12'($urandom_range(0, 4095)));
                end else begin
                    feed_item(ACTION_STORE, $urandom_range(0, 1) ? 12'd4095 : 12'd0);
                end
            end
            send_item(ACTION_CAPTURE, '0);
            settle_results();
        end

        $display("covered %0d stored samples and %0d captures, %0d of them on a found edge",
                 samples_sent, captures_seen, edges_found);
        $display("%0d result pairs checked over %0d register writes", pairs_checked, settings_used);
        if (fail_count == 0 && pending_pairs == 0) begin
            $display("scope_edge_trigger_capture: match");
        end else begin
            $display("scope_edge_trigger_capture: mismatch");
        end
        $finish;
    end

endmodule
